@@ hw/rtl/sjsr_pkg.sv @@
// ----------------------------------------------------------------------------
// sjsr_pkg: shared types and constants of the servo slew ramp unit
// Channel count, angle format, pulse arithmetic constants, command and
// register codes, and the job record handed from the front to the back.
// ----------------------------------------------------------------------------
package sjsr_pkg;

  localparam int CHANNELS  = 6;
  localparam int MAX_ANGLE = 180;
  localparam int FRAC_BITS = 4;

  // Fixed field widths of the ports
  localparam int CMD_W   = 2;
  localparam int CH_W    = 3;
  localparam int ANG_W   = 12;
  localparam int PULSE_W = 12;
  localparam int IVL_W   = 16;
  localparam int REG_W   = 2;
  localparam int DATA_W  = 16;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEG_W    = $clog2(MAX_ANGLE + 1);

  localparam int ONE_DEG  = 1 << FRAC_BITS;
  localparam int HALF_DEG = ONE_DEG >> 1;
  localparam int MAX_FIX  = MAX_ANGLE << FRAC_BITS;
  localparam int MID_RAW  = 90 << FRAC_BITS;
  localparam int MID_FIX  = (MID_RAW > MAX_FIX) ? MAX_FIX : MID_RAW;

  // floor(p / MAX_ANGLE) as (p * RECIP) >> RECIP_SH, exact for p < 2**PROD_W
  localparam int    PROD_W   = DEG_W + PULSE_W;
  localparam int    RECIP_SH = PROD_W + DEG_W;
  localparam longint RECIP   = ((64'd1 << RECIP_SH) + MAX_ANGLE - 1) / MAX_ANGLE;
  localparam int    RECIP_W  = $clog2(RECIP + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_SET_TARGET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_JUMP       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;

  localparam logic [REG_W-1:0] REG_MIN_PULSE     = 2'd0;
  localparam logic [REG_W-1:0] REG_MAX_PULSE     = 2'd1;
  localparam logic [REG_W-1:0] REG_STEP_INTERVAL = 2'd2;

  localparam logic [PULSE_W-1:0] RST_MIN_PULSE     = 12'd500;
  localparam logic [PULSE_W-1:0] RST_MAX_PULSE     = 12'd2500;
  localparam logic [IVL_W-1:0]   RST_STEP_INTERVAL = 16'd20;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [DEG_W-1:0] deg;
    logic             moving;
    logic             last;
  } job_t;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] span;
  } pulse_cfg_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } queue_stat_t;

  typedef struct packed {
    logic walking;
    logic stepping;
  } front_stat_t;

  // Round half up to whole degrees, one bit of headroom
  function automatic logic [ANG_W:0] whole_deg(input logic [ANG_W-1:0] a);
    logic [ANG_W:0] sum;
    sum = {1'b0, a} + (ANG_W + 1)'(HALF_DEG);
    return sum >> FRAC_BITS;
  endfunction

  function automatic logic [DEG_W-1:0] to_deg(input logic [ANG_W-1:0] a);
    logic [ANG_W:0] wd;
    wd = whole_deg(a);
    if (wd > (ANG_W + 1)'(MAX_ANGLE)) begin
      wd = (ANG_W + 1)'(MAX_ANGLE);
    end
    return DEG_W'(wd);
  endfunction

endpackage

@@ hw/rtl/sjsr_queue.sv @@
// ----------------------------------------------------------------------------
// sjsr_queue: job queue between front and back
// Small register FIFO of job records; one push and one pop per cycle.
// ----------------------------------------------------------------------------
module sjsr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sjsr_pkg::job_t       push_job,
  input  logic                 pop,
  output sjsr_pkg::job_t       head_job,
  output sjsr_pkg::queue_stat_t stat
);
  import sjsr_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);

endmodule

@@ hw/rtl/sjsr_front.sv @@
// ----------------------------------------------------------------------------
// sjsr_front: command decode and angle state
// Holds current and target angles and the tick counter, applies set-target
// and jump, runs the ramp step for all channels at once, then walks the
// changed channels and queues one job per result.
// ----------------------------------------------------------------------------
module sjsr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sjsr_pkg::CMD_W-1:0]     in_command,
  input  logic [sjsr_pkg::CH_W-1:0]      in_channel,
  input  logic [sjsr_pkg::ANG_W-1:0]     in_angle,
  input  logic [sjsr_pkg::IVL_W-1:0]     step_interval,
  input  logic                           q_full,
  output logic                           push,
  output sjsr_pkg::job_t                 push_job,
  output sjsr_pkg::front_stat_t          stat
);
  import sjsr_pkg::*;

  logic [ANG_W-1:0]    cur_r [CHANNELS];
  logic [ANG_W-1:0]    tgt_r [CHANNELS];
  logic [ANG_W-1:0]    ramp_nxt [CHANNELS];
  logic [CHANNELS-1:0] chg_mask;
  logic [CHANNELS-1:0] mask_r, mask_nxt;
  logic [IVL_W-1:0]    wait_r, wait_nxt;

  logic                in_acc;
  logic                walking;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [ANG_W-1:0]    ang_sat;
  logic [ANG_W:0]      jump_raw;
  logic [ANG_W-1:0]    jump_ang;
  logic [IVL_W-1:0]    wait_inc;
  logic [IVL_W-1:0]    interval;
  logic                step;
  logic [CH_IDX_W-1:0] sel_idx;
  logic [CHANNELS-1:0] sel_onehot;

  assign walking  = |mask_r;
  assign in_ready = !walking && !q_full;
  assign in_acc   = in_valid && in_ready;

  assign ch_ok   = 32'(in_channel) < CHANNELS;
  assign ch_idx  = CH_IDX_W'(in_channel);
  assign ang_sat = (32'(in_angle) > MAX_FIX) ? ANG_W'(MAX_FIX) : in_angle;

  always_comb begin
    jump_raw = whole_deg(ang_sat) << FRAC_BITS;
    if (32'(jump_raw) > MAX_FIX) begin
      jump_raw = (ANG_W + 1)'(MAX_FIX);
    end
    jump_ang = ANG_W'(jump_raw);
  end

  // Tick counter saturates; an interval of zero acts as one
  assign wait_inc = (wait_r == '1) ? wait_r : wait_r + 1'b1;
  assign interval = (step_interval == '0) ? IVL_W'(1) : step_interval;
  assign step     = (in_command == CMD_TICK) && (wait_inc >= interval);

  // Ramp step, evaluated for every channel in parallel
  always_comb begin
    logic [ANG_W:0] cur_w;
    logic [ANG_W:0] tgt_w;
    for (int i = 0; i < CHANNELS; i++) begin
      cur_w       = {1'b0, cur_r[i]};
      tgt_w       = {1'b0, tgt_r[i]};
      ramp_nxt[i] = cur_r[i];
      chg_mask[i] = 1'b1;
      if (cur_w + (ANG_W + 1)'(ONE_DEG) < tgt_w) begin
        ramp_nxt[i] = cur_r[i] + ANG_W'(ONE_DEG);
      end else if (cur_w > tgt_w + (ANG_W + 1)'(ONE_DEG)) begin
        ramp_nxt[i] = cur_r[i] - ANG_W'(ONE_DEG);
      end else if (whole_deg(cur_r[i]) != whole_deg(tgt_r[i])) begin
        ramp_nxt[i] = tgt_r[i];
      end else begin
        chg_mask[i] = 1'b0;
      end
    end
  end

  // Lowest pending channel goes out first
  always_comb begin
    sel_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel_idx = CH_IDX_W'(i);
      end
    end
    sel_onehot = CHANNELS'(1) << sel_idx;
  end

  always_comb begin
    wait_nxt = wait_r;
    mask_nxt = mask_r;
    if (in_acc && (in_command == CMD_TICK)) begin
      wait_nxt = step ? '0 : wait_inc;
      if (step) begin
        mask_nxt = chg_mask;
      end
    end else if (walking && !q_full) begin
      mask_nxt = mask_r & ~sel_onehot;
    end
  end

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (walking) begin
      push            = !q_full;
      push_job.ch     = CH_W'(sel_idx);
      push_job.deg    = to_deg(cur_r[sel_idx]);
      push_job.moving = 1'b1;
      push_job.last   = ((mask_r & ~sel_onehot) == '0);
    end else if (in_acc) begin
      case (in_command)
        CMD_JUMP: begin
          push            = ch_ok;
          push_job.ch     = in_channel;
          push_job.deg    = to_deg(jump_ang);
          push_job.moving = 1'b1;
          push_job.last   = 1'b1;
        end
        CMD_TICK: begin
          // settled status when the step moves nothing
          push          = step && (chg_mask == '0);
          push_job.last = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i] <= ANG_W'(MID_FIX);
        tgt_r[i] <= ANG_W'(MID_FIX);
      end
      wait_r <= '0;
      mask_r <= '0;
    end else begin
      wait_r <= wait_nxt;
      mask_r <= mask_nxt;
      if (in_acc) begin
        case (in_command)
          CMD_SET_TARGET: begin
            if (ch_ok) begin
              tgt_r[ch_idx] <= ang_sat;
            end
          end
          CMD_JUMP: begin
            if (ch_ok) begin
              cur_r[ch_idx] <= jump_ang;
              tgt_r[ch_idx] <= jump_ang;
            end
          end
          CMD_TICK: begin
            if (step) begin
              for (int i = 0; i < CHANNELS; i++) begin
                cur_r[i] <= ramp_nxt[i];
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign stat.walking  = walking;
  assign stat.stepping = in_acc && step;

endmodule

@@ hw/rtl/sjsr_back.sv @@
// ----------------------------------------------------------------------------
// sjsr_back: pulse width pipeline
// Three stages: degree times span, multiply by the reciprocal of the
// maximum angle, add the minimum pulse into the output register.
// ----------------------------------------------------------------------------
module sjsr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sjsr_pkg::job_t                 head_job,
  input  logic                           q_empty,
  output logic                           pop,
  input  sjsr_pkg::pulse_cfg_t           cfg,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sjsr_pkg::CH_W-1:0]      out_channel,
  output logic [sjsr_pkg::PULSE_W-1:0]   out_pulse_width,
  output logic                           out_moving,
  output logic                           out_last
);
  import sjsr_pkg::*;

  logic                  v1_r, v2_r, v3_r;
  job_t                  job1_r, job2_r;
  logic [PROD_W-1:0]     prod1_r;
  logic [PULSE_W-1:0]    quot2_r;
  logic [CH_W-1:0]       ch3_r;
  logic [PULSE_W-1:0]    pw3_r;
  logic                  mv3_r, last3_r;

  logic                  rdy1, rdy2, rdy3;
  logic [PROD_W+RECIP_W-1:0] scaled;
  logic [PULSE_W:0]      pulse_sum;

  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign pop  = !q_empty && rdy1;

  assign scaled    = prod1_r * RECIP_W'(RECIP);
  assign pulse_sum = {1'b0, cfg.min_pulse} + {1'b0, quot2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= pop;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && pop) begin
      job1_r  <= head_job;
      prod1_r <= PROD_W'(head_job.deg) * PROD_W'(cfg.span);
    end
    if (rdy2 && v1_r) begin
      job2_r  <= job1_r;
      quot2_r <= PULSE_W'(scaled >> RECIP_SH);
    end
    if (rdy3 && v2_r) begin
      ch3_r   <= job2_r.moving ? job2_r.ch : '0;
      pw3_r   <= job2_r.moving ? PULSE_W'(pulse_sum) : '0;
      mv3_r   <= job2_r.moving;
      last3_r <= job2_r.last;
    end
  end

  assign out_valid       = v3_r;
  assign out_channel     = ch3_r;
  assign out_pulse_width = pw3_r;
  assign out_moving      = mv3_r;
  assign out_last        = last3_r;

endmodule

@@ hw/rtl/servo_joint_slew_ramp_unit.sv @@
// ----------------------------------------------------------------------------
// servo_joint_slew_ramp_unit: servo slew-rate limiter
// Per-channel current/target angles, ramped one degree per step interval,
// with a pulse width result for every channel that moves.
//
//   channel  direction  payload                                   handshake
//   in_      input      command, channel, angle                   valid/ready
//   out_     output     channel, pulse_width, moving, last        valid/ready
//   cfg_     input      index, data                               valid/ready
//
// Set-target and jump act on the angle state in the front; a jump result
// passes through the queue and the back stages to the output register.
// A ramp step that changes channels is followed by a walk that queues one
// job per changed channel through the single queue write port; the front
// holds in_ready low during that walk. The back pipeline yields one pulse
// width per cycle when out_ready is high. Reset is synchronous; out_ready
// low stalls the back and, once the four-entry queue fills, the front.
// ----------------------------------------------------------------------------
module servo_joint_slew_ramp_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sjsr_pkg::CMD_W-1:0]     in_command,
  input  logic [sjsr_pkg::CH_W-1:0]      in_channel,
  input  logic [sjsr_pkg::ANG_W-1:0]     in_angle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sjsr_pkg::CH_W-1:0]      out_channel,
  output logic [sjsr_pkg::PULSE_W-1:0]   out_pulse_width,
  output logic                           out_moving,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sjsr_pkg::REG_W-1:0]     cfg_index,
  input  logic [sjsr_pkg::DATA_W-1:0]    cfg_data
);
  import sjsr_pkg::*;

  logic [PULSE_W-1:0] min_pulse_r;
  logic [PULSE_W-1:0] max_pulse_r;
  logic [IVL_W-1:0]   step_ivl_r;
  pulse_cfg_t         pcfg;

  logic               push;
  job_t               push_job;
  logic               pop;
  job_t               head_job;
  queue_stat_t        q_stat;
  front_stat_t        fr_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= RST_MIN_PULSE;
      max_pulse_r <= RST_MAX_PULSE;
      step_ivl_r  <= RST_STEP_INTERVAL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_PULSE:     min_pulse_r <= PULSE_W'(cfg_data);
        REG_MAX_PULSE:     max_pulse_r <= PULSE_W'(cfg_data);
        REG_STEP_INTERVAL: step_ivl_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Span below zero clamps to zero
  assign pcfg.min_pulse = min_pulse_r;
  assign pcfg.span      = (max_pulse_r > min_pulse_r) ? max_pulse_r - min_pulse_r : '0;

  sjsr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_channel    (in_channel),
    .in_angle      (in_angle),
    .step_interval (step_ivl_r),
    .q_full        (q_stat.full),
    .push          (push),
    .push_job      (push_job),
    .stat          (fr_stat)
  );

  sjsr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  sjsr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .q_empty         (q_stat.empty),
    .pop             (pop),
    .cfg             (pcfg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_pulse_width (out_pulse_width),
    .out_moving      (out_moving),
    .out_last        (out_last)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("job queue count beyond depth");

  a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    fr_stat.walking |-> !in_ready)
    else $error("input taken during step walk");

  a_step_then_walk_or_status: assert property (@(posedge clk) disable iff (!rst_n)
    fr_stat.stepping |=> (fr_stat.walking || $past(push)))
    else $error("ramp step produced neither walk nor status");

  a_status_format: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_moving |-> out_last && out_channel == '0 && out_pulse_width == '0)
    else $error("malformed settled status");

endmodule
